>>> rtl/core/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

  localparam int NUM_CHANNELS   = 16;
  localparam int CHANNEL_WIDTH  = 11;
  localparam int FRAME_CHANNELS = 16;
  localparam int IDX_W          = 4;
  localparam int FLAG_W         = 4;
  localparam int BYTE_W         = 8;
  localparam int POS_W          = 5;
  localparam int BUF_W          = 18;
  localparam int HELD_W         = 5;
  localparam int NCH_W          = 5;
  localparam int RAM_AW         = IDX_W + 1;   // bank bit + channel index
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = CHANNEL_WIDTH;

  localparam logic [POS_W-1:0] DATA_BYTES = POS_W'(22);
  localparam logic [POS_W-1:0] FLAG_BYTE  = POS_W'(22);
  localparam logic [POS_W-1:0] IDLE_POS   = POS_W'(23);

  localparam logic [CHANNEL_WIDTH-1:0] MIN_RESET = CHANNEL_WIDTH'(172);
  localparam logic [CHANNEL_WIDTH-1:0] MAX_RESET = CHANNEL_WIDTH'(1812);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE = CFG_IDX_W'(2);

  // frame decision handed from the unpacker to the result sequencer
  typedef struct packed {
    logic              start;
    logic              bank;
    logic              store_valid;
    logic [FLAG_W-1:0] flags;
    logic              accepted;
  } sfd_commit_t;

  typedef struct packed {
    logic                     en;
    logic [RAM_AW-1:0]        addr;
    logic [CHANNEL_WIDTH-1:0] data;
  } sfd_wr_t;

endpackage
`default_nettype wire

>>> rtl/core/sfd_if.sv
`default_nettype none
interface sfd_in_if;
  logic                         valid;
  logic                         ready;
  logic [sfd_pkg::BYTE_W-1:0]   byte_value;
  logic                         frame_start;
  modport source (output valid, output byte_value, output frame_start, input ready);
  modport sink (input valid, input byte_value, input frame_start, output ready);
endinterface

interface sfd_out_if;
  logic                                valid;
  logic                                ready;
  logic [sfd_pkg::IDX_W-1:0]           channel_index;
  logic [sfd_pkg::CHANNEL_WIDTH-1:0]   channel_value;
  logic [sfd_pkg::FLAG_W-1:0]          flag_bits;
  logic                                frame_accepted;
  logic                                last_result;
  modport source (output valid, output channel_index, output channel_value,
                  output flag_bits, output frame_accepted, output last_result,
                  input ready);
  modport sink (input valid, input channel_index, input channel_value,
                input flag_bits, input frame_accepted, input last_result,
                output ready);
endinterface

interface sfd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sfd_pkg::CFG_IDX_W-1:0]     index;
  logic [sfd_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sfd_chan_ram.sv
`default_nettype none
module sfd_chan_ram (
  input  wire logic                              clk,
  input  wire sfd_pkg::sfd_wr_t                  wr,
  input  wire logic                              rd_en,
  input  wire logic [sfd_pkg::RAM_AW-1:0]        rd_addr,
  output logic [sfd_pkg::CHANNEL_WIDTH-1:0]      rd_data_r
);

  logic [sfd_pkg::CHANNEL_WIDTH-1:0] mem [2**sfd_pkg::RAM_AW];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/sfd_unpack.sv
`default_nettype none
module sfd_unpack (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sfd_in_if.sink             in_ch,
  sfd_cfg_if.sink            cfg_ch,
  input  wire logic          burst_busy,
  output sfd_pkg::sfd_wr_t   wr,
  output sfd_pkg::sfd_commit_t commit
);

  logic [sfd_pkg::CHANNEL_WIDTH-1:0] min_r, max_r;
  logic                              chk_en_r;

  logic [sfd_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [sfd_pkg::BUF_W-1:0]  buf_r, buf_nxt;
  logic [sfd_pkg::HELD_W-1:0] held_r, held_nxt;
  logic [sfd_pkg::NCH_W-1:0]  nch_r, nch_nxt;
  logic                       ok_r, ok_nxt;
  logic                       bank_r, bank_nxt;
  logic                       sv_r, sv_nxt;
  logic [sfd_pkg::FLAG_W-1:0] flag_r, flag_nxt;

  logic                              in_fire;
  logic [sfd_pkg::BUF_W-1:0]         acc;
  logic [sfd_pkg::HELD_W-1:0]        held_add;
  logic [sfd_pkg::CHANNEL_WIDTH-1:0] chv;

  // a new decision must wait until the previous burst has read its bank
  assign in_ch.ready  = !(burst_busy && (pos_r == sfd_pkg::FLAG_BYTE));
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= sfd_pkg::MIN_RESET;
      max_r    <= sfd_pkg::MAX_RESET;
      chk_en_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        sfd_pkg::REG_MIN_VALUE:    min_r    <= cfg_ch.data;
        sfd_pkg::REG_MAX_VALUE:    max_r    <= cfg_ch.data;
        sfd_pkg::REG_CHECK_ENABLE: chk_en_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    buf_nxt  = buf_r;
    held_nxt = held_r;
    nch_nxt  = nch_r;
    ok_nxt   = ok_r;
    bank_nxt = bank_r;
    sv_nxt   = sv_r;
    flag_nxt = flag_r;
    acc      = '0;
    held_add = '0;
    chv      = '0;
    wr       = '0;
    commit   = '0;
    if (in_fire) begin
      if (in_ch.frame_start) begin
        pos_nxt  = '0;
        buf_nxt  = '0;
        held_nxt = '0;
        nch_nxt  = '0;
        ok_nxt   = 1'b1;
      end
      if (pos_nxt < sfd_pkg::DATA_BYTES) begin
        acc      = buf_nxt | (sfd_pkg::BUF_W'(in_ch.byte_value) << held_nxt);
        held_add = held_nxt + sfd_pkg::HELD_W'(sfd_pkg::BYTE_W);
        // eight new bits complete at most one channel
        if (held_add >= sfd_pkg::HELD_W'(sfd_pkg::CHANNEL_WIDTH)) begin
          chv      = acc[sfd_pkg::CHANNEL_WIDTH-1:0];
          buf_nxt  = acc >> sfd_pkg::CHANNEL_WIDTH;
          held_nxt = held_add - sfd_pkg::HELD_W'(sfd_pkg::CHANNEL_WIDTH);
          if (nch_nxt < sfd_pkg::NCH_W'(sfd_pkg::NUM_CHANNELS)) begin
            wr.en   = 1'b1;
            wr.addr = {~bank_r, nch_nxt[sfd_pkg::IDX_W-1:0]};
            wr.data = chv;
            if (chk_en_r && ((chv < min_r) || (chv > max_r))) begin
              ok_nxt = 1'b0;
            end
          end
          if (nch_nxt < sfd_pkg::NCH_W'(sfd_pkg::FRAME_CHANNELS)) begin
            nch_nxt = nch_nxt + 1'b1;
          end
        end else begin
          buf_nxt  = acc;
          held_nxt = held_add;
        end
        pos_nxt = pos_nxt + 1'b1;
      end else if (pos_nxt == sfd_pkg::FLAG_BYTE) begin
        pos_nxt = sfd_pkg::IDLE_POS;
        if (ok_nxt) begin
          bank_nxt = ~bank_r;
          sv_nxt   = 1'b1;
          flag_nxt = in_ch.byte_value[sfd_pkg::FLAG_W-1:0];
        end
        commit.start       = 1'b1;
        commit.bank        = bank_nxt;
        commit.store_valid = sv_nxt;
        commit.flags       = flag_nxt;
        commit.accepted    = ok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= sfd_pkg::IDLE_POS;
      buf_r  <= '0;
      held_r <= '0;
      nch_r  <= '0;
      ok_r   <= 1'b1;
      bank_r <= 1'b0;
      sv_r   <= 1'b0;
      flag_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      buf_r  <= buf_nxt;
      held_r <= held_nxt;
      nch_r  <= nch_nxt;
      ok_r   <= ok_nxt;
      bank_r <= bank_nxt;
      sv_r   <= sv_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/sfd_burst.sv
`default_nettype none
module sfd_burst (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire sfd_pkg::sfd_commit_t               commit,
  output logic                                    busy,
  output logic                                    rd_en,
  output logic [sfd_pkg::RAM_AW-1:0]              rd_addr,
  input  wire logic [sfd_pkg::CHANNEL_WIDTH-1:0]  rd_data,
  sfd_out_if.source                               out_ch
);

  localparam int REM_W = sfd_pkg::IDX_W + 1;

  logic [REM_W-1:0]            rem_r;
  logic [sfd_pkg::IDX_W-1:0]   rd_idx_r;
  logic                        s1_v_r;
  logic [sfd_pkg::IDX_W-1:0]   s1_idx_r;
  logic                        bank_r, sv_r, acc_r;
  logic [sfd_pkg::FLAG_W-1:0]  flag_r;

  logic                              out_valid_r;
  logic [sfd_pkg::IDX_W-1:0]         out_idx_r;
  logic [sfd_pkg::CHANNEL_WIDTH-1:0] out_val_r;
  logic [sfd_pkg::FLAG_W-1:0]        out_flag_r;
  logic                              out_acc_r;
  logic                              out_last_r;

  logic move;

  // read data register holds while stalled, acting as the skid slot
  assign move    = s1_v_r && (!out_valid_r || out_ch.ready);
  assign rd_en   = (rem_r != '0) && (!s1_v_r || move);
  assign rd_addr = {bank_r, rd_idx_r};
  assign busy    = (rem_r != '0) || s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      rd_idx_r    <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit.start) begin
        rem_r    <= REM_W'(sfd_pkg::NUM_CHANNELS);
        rd_idx_r <= '0;
      end else if (rd_en) begin
        rem_r    <= rem_r - 1'b1;
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (rd_en) begin
        s1_v_r <= 1'b1;
      end else if (move) begin
        s1_v_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit.start) begin
      bank_r <= commit.bank;
      sv_r   <= commit.store_valid;
      flag_r <= commit.flags;
      acc_r  <= commit.accepted;
    end
    if (rd_en) begin
      s1_idx_r <= rd_idx_r;
    end
    if (move) begin
      out_idx_r  <= s1_idx_r;
      // committed bank reads as zero until the first accepted frame
      out_val_r  <= sv_r ? rd_data : '0;
      out_flag_r <= flag_r;
      out_acc_r  <= acc_r;
      out_last_r <= (s1_idx_r == sfd_pkg::IDX_W'(sfd_pkg::NUM_CHANNELS - 1));
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.channel_index  = out_idx_r;
  assign out_ch.channel_value  = out_val_r;
  assign out_ch.flag_bits      = out_flag_r;
  assign out_ch.frame_accepted = out_acc_r;
  assign out_ch.last_result    = out_last_r;

endmodule
`default_nettype wire

>>> rtl/core/sbus_channel_frame_decoder.sv
// Servo frame decoder.
// in_ch: one payload byte per transaction; frame_start marks byte 0. Bytes
//   0..21 are unpacked LSB first into sixteen 11-bit channels, range checked
//   against min/max when check_enable is set. Byte 22 decides the frame.
// out_ch: after byte 22, sixteen transactions (channel 0..15) with the
//   stored channel, stored flag nibble and the accept mark; last_result on
//   channel 15. Bytes outside a frame produce nothing.
// cfg_ch: index 0 min_value, 1 max_value, 2 check_enable; always ready.
// Channels live in a two-bank RAM: the new frame fills one bank, an accepted
//   frame flips the bank pointer, so commit takes no copy.
// Throughput: one byte per cycle while in_ch.ready is high; results stream at
//   one per cycle from the RAM read port while the receiver takes them.
// in_ch.ready drops only when a flag byte is due while the previous burst
//   still has RAM reads outstanding or read data not yet moved to the
//   output register.
// A stalled receiver holds out_ch; the read data register acts as skid
//   storage, so reads resume without loss.
// Reset: idle, stored channels and flags read as zero, registers to
//   172 / 1812 / 1.
`default_nettype none
module sbus_channel_frame_decoder (
  input  wire logic clk,
  input  wire logic rst_n,
  sfd_in_if.sink    in_ch,
  sfd_out_if.source out_ch,
  sfd_cfg_if.sink   cfg_ch
);

  sfd_pkg::sfd_wr_t     wr;
  sfd_pkg::sfd_commit_t commit;
  logic                              burst_busy;
  logic                              rd_en;
  logic [sfd_pkg::RAM_AW-1:0]        rd_addr;
  logic [sfd_pkg::CHANNEL_WIDTH-1:0] rd_data;

  sfd_unpack u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .burst_busy (burst_busy),
    .wr         (wr),
    .commit     (commit)
  );

  sfd_chan_ram u_ram (
    .clk       (clk),
    .wr        (wr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  sfd_burst u_burst (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (commit),
    .busy    (burst_busy),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

>>> dv/sbus_channel_frame_decoder_tb.sv
module sbus_channel_frame_decoder_tb;
  import sfd_pkg::*;

  // Cycles with no transaction on any channel before the run is abandoned.
  // The longest legal quiet stretch is the forced receiver hold (HOLD_CYCLES)
  // plus a random stall tail, so this leaves a wide margin.
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_BYTES  = 36;
  localparam int NUM_PHASES   = 6;
  localparam int MAX_REPORTS  = 30;
  localparam int FRAME_BYTES  = 23;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              start;
  } payload_byte_t;

  typedef struct packed {
    logic [IDX_W-1:0]         index;
    logic [CHANNEL_WIDTH-1:0] value;
    logic [FLAG_W-1:0]        flags;
    logic                     accepted;
    logic                     last;
  } chan_report_t;

  logic clk;
  logic rst_n;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();
  sfd_cfg_if cfg_ch ();

  sbus_channel_frame_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // stimulus and scoreboard state
  payload_byte_t byte_q[$];
  chan_report_t  expected_reports[$];
  int            tx_idle_pct;
  int            rx_idle_pct;
  int            hold_req;
  logic          in_taken;
  int            errors;
  int            stall_cycles;
  int            frame_bytes_queued;
  int            bytes_taken;
  int            frames_decided;
  int            frames_committed;
  int            reports_checked;
  int            settings_used;

  // decoder shadow state
  logic [POS_W-1:0]         frame_pos;
  logic [BUF_W-1:0]         bit_acc;
  logic [HELD_W-1:0]        acc_bits;
  logic [NCH_W-1:0]         chan_cursor;
  logic [CHANNEL_WIDTH-1:0] chan_pending [FRAME_CHANNELS];
  logic                     range_ok;
  logic [CHANNEL_WIDTH-1:0] chan_store [FRAME_CHANNELS];
  logic [FLAG_W-1:0]        flag_store;
  logic [CHANNEL_WIDTH-1:0] min_limit;
  logic [CHANNEL_WIDTH-1:0] max_limit;
  logic                     check_on;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic shadow_reset();
    min_limit   = MIN_RESET;
    max_limit   = MAX_RESET;
    check_on    = 1'b1;
    frame_pos   = IDLE_POS;
    bit_acc     = '0;
    acc_bits    = '0;
    chan_cursor = '0;
    range_ok    = 1'b1;
    flag_store  = '0;
    for (int i = 0; i < FRAME_CHANNELS; i++) begin
      chan_pending[i] = '0;
      chan_store[i]   = '0;
    end
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MIN_VALUE:    min_limit = data;
      REG_MAX_VALUE:    max_limit = data;
      REG_CHECK_ENABLE: check_on  = data[0];
      default: ;
    endcase
  endtask

  // Unpack one payload byte; on the flag byte, commit if accepted and queue the burst.
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic start);
    logic [CHANNEL_WIDTH-1:0] v;
    logic                     ok;
    chan_report_t             rep;
    if (start) begin
      frame_pos   = '0;
      bit_acc     = '0;
      acc_bits    = '0;
      chan_cursor = '0;
      range_ok    = 1'b1;
    end
    if (frame_pos < DATA_BYTES) begin
      bit_acc  = bit_acc | (BUF_W'(b) << acc_bits);
      acc_bits = acc_bits + HELD_W'(8);
      while (acc_bits >= HELD_W'(CHANNEL_WIDTH)) begin
        v        = bit_acc[CHANNEL_WIDTH-1:0];
        bit_acc  = bit_acc >> CHANNEL_WIDTH;
        acc_bits = acc_bits - HELD_W'(CHANNEL_WIDTH);
        if (chan_cursor < NUM_CHANNELS && chan_cursor < FRAME_CHANNELS) begin
          chan_pending[chan_cursor[IDX_W-1:0]] = v;
          if (check_on && (v < min_limit || v > max_limit))
            range_ok = 1'b0;
        end
        if (chan_cursor < FRAME_CHANNELS)
          chan_cursor = chan_cursor + 1'b1;
      end
      frame_pos = frame_pos + 1'b1;
    end else if (frame_pos == FLAG_BYTE) begin
      frame_pos = IDLE_POS;
      ok        = range_ok;
      frames_decided++;
      if (ok) begin
        frames_committed++;
        for (int i = 0; i < NUM_CHANNELS; i++)
          chan_store[i] = chan_pending[i];
        flag_store = b[FLAG_W-1:0];
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rep.index    = IDX_W'(i);
        rep.value    = chan_store[i];
        rep.flags    = flag_store;
        rep.accepted = ok;
        rep.last     = (i + 1 == NUM_CHANNELS);
        expected_reports.push_back(rep);
      end
    end
  endtask

  // monitor: sample all handshakes at the rising edge
  always @(posedge clk) begin : monitor
    chan_report_t got;
    chan_report_t want;
    logic         moved;
    moved    = 1'b0;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        got   = {out_ch.channel_index, out_ch.channel_value, out_ch.flag_bits,
                 out_ch.frame_accepted, out_ch.last_result};
        if (expected_reports.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result: expected none, actual %0d/%0d/%h/%b/%b",
                     $time, got.index, got.value, got.flags, got.accepted, got.last);
        end else begin
          want = expected_reports.pop_front();
          reports_checked++;
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: result mismatch: expected idx=%0d val=%0d flags=%h acc=%b last=%b",
                       $time, want.index, want.value, want.flags, want.accepted, want.last);
              $display("%0t: result mismatch: actual   idx=%0d val=%0d flags=%h acc=%b last=%b",
                       $time, got.index, got.value, got.flags, got.accepted, got.last);
            end
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        apply_reg(cfg_ch.index, cfg_ch.data);
      end
      if (in_ch.valid && in_ch.ready) begin
        moved    = 1'b1;
        in_taken = 1'b1;
        bytes_taken++;
        decode_byte(in_ch.byte_value, in_ch.frame_start);
      end
    end
    if (moved)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // byte driver: holds a byte until taken, random gaps between bytes
  always @(negedge clk) begin : byte_driver
    payload_byte_t nxt;
    logic          drive_v;
    drive_v = in_ch.valid && !in_taken;
    if (!drive_v && rst_n && byte_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
      nxt               = byte_q.pop_front();
      in_ch.byte_value  <= nxt.value;
      in_ch.frame_start <= nxt.start;
      drive_v           = 1'b1;
    end else if (!drive_v) begin
      in_ch.byte_value  <= BYTE_W'($urandom);
      in_ch.frame_start <= 1'($urandom);
    end
    in_ch.valid <= drive_v;
  end

  // result receiver: random backpressure, plus long holds on request
  always @(negedge clk) begin : result_sink
    int hold_left;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic queue_byte(input logic [BYTE_W-1:0] v, input logic start);
    payload_byte_t pb;
    pb.value = v;
    pb.start = start;
    byte_q.push_back(pb);
  endtask

  // push the first 'keep' bytes of a frame: 22 packed data bytes, then flags
  task automatic queue_frame(input logic [175:0] chans, input logic [BYTE_W-1:0] flags,
                             input int keep);
    for (int k = 0; k < keep && k < FRAME_BYTES; k++) begin
      queue_byte((k == FRAME_BYTES - 1) ? flags : chans[k*8 +: 8], k == 0);
      frame_bytes_queued++;
    end
  endtask

  function automatic logic [175:0] make_channels(input logic [CHANNEL_WIDTH-1:0] lo,
                                                 input logic [CHANNEL_WIDTH-1:0] hi,
                                                 input logic clean);
    logic [175:0]             chans;
    logic [CHANNEL_WIDTH-1:0] v;
    int                       r;
    for (int i = 0; i < FRAME_CHANNELS; i++) begin
      r = $urandom_range(99);
      if (clean && lo <= hi)
        v = (r < 15) ? lo : (r < 30) ? hi : CHANNEL_WIDTH'($urandom_range(hi, lo));
      else if (r < 10) v = lo - 1'b1;
      else if (r < 20) v = hi + 1'b1;
      else if (r < 30) v = lo;
      else if (r < 40) v = hi;
      else if (r < 45) v = '0;
      else if (r < 50) v = '1;
      else             v = CHANNEL_WIDTH'($urandom);
      chans[i*CHANNEL_WIDTH +: CHANNEL_WIDTH] = v;
    end
    return chans;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for every byte to be taken and every result to come back
  task automatic wait_idle();
    do @(negedge clk);
    while (byte_q.size() != 0 || in_ch.valid || expected_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [175:0]             chans;
    logic [CHANNEL_WIDTH-1:0] lo;
    logic [CHANNEL_WIDTH-1:0] hi;
    logic [CHANNEL_WIDTH-1:0] tmp;
    logic                     en;
    int                       phase_base;
    int                       r;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.byte_value   = '0;
    in_ch.frame_start  = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_MIN_VALUE;
    cfg_ch.data        = '0;
    tx_idle_pct        = 36;
    rx_idle_pct        = 79;
    hold_req           = 0;
    in_taken           = 1'b0;
    errors             = 0;
    stall_cycles       = 0;
    frame_bytes_queued = 0;
    bytes_taken        = 0;
    frames_decided     = 0;
    frames_committed   = 0;
    reports_checked    = 0;
    settings_used      = 1;
    shadow_reset();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray bytes while idle, then frames under reset limits
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    for (int i = 0; i < FRAME_CHANNELS; i++)
      chans[i*CHANNEL_WIDTH +: CHANNEL_WIDTH] = i[0] ? MAX_RESET : MIN_RESET;
    queue_frame(chans, 8'hA5, FRAME_BYTES);
    queue_byte(8'h3C, 1'b0);  // after the flag byte: dropped
    for (int i = 0; i < FRAME_CHANNELS; i++)
      chans[i*CHANNEL_WIDTH +: CHANNEL_WIDTH] = i[0] ? '1 : '0;
    queue_frame(chans, 8'h5A, FRAME_BYTES);  // out of range, old values kept
    queue_frame(chans, 8'h00, 9);            // cut short by the next start
    for (int i = 0; i < FRAME_CHANNELS; i++)
      chans[i*CHANNEL_WIDTH +: CHANNEL_WIDTH] = i[0] ? 11'h2AA : 11'h555;
    queue_frame(chans, 8'hFF, FRAME_BYTES);
    wait_idle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin lo = '0;       hi = '1;        en = 1'b1; end
        1: begin lo = 11'd900;  hi = 11'd1100;  en = 1'b1; end
        2: begin lo = '1;       hi = '0;        en = 1'b1; end  // min above max
        3: begin lo = '0;       hi = '0;        en = 1'b0; end
        4: begin
          lo = CHANNEL_WIDTH'($urandom);
          hi = CHANNEL_WIDTH'($urandom);
          if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
          en = 1'b1;
        end
        default: begin lo = MIN_RESET; hi = MAX_RESET; en = 1'b1; end
      endcase
      write_reg(REG_MIN_VALUE, lo);
      write_reg(REG_MAX_VALUE, hi);
      write_reg(REG_CHECK_ENABLE, CFG_DATA_W'(en));
      settings_used++;
      @(posedge clk);

      if (phase < 2) begin
        tx_idle_pct = 36;
        rx_idle_pct = 79;
      end else if (phase < 4) begin
        tx_idle_pct = 79;
        rx_idle_pct = 36;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      phase_base = frame_bytes_queued;
      // long receiver hold over two full frames: the second flag byte stalls
      if (phase == 1 || phase == 4) begin
        hold_req = HOLD_CYCLES;
        queue_frame(make_channels(lo, hi, 1'b1), BYTE_W'($urandom), FRAME_BYTES);
        queue_frame(make_channels(lo, hi, 1'b1), BYTE_W'($urandom), FRAME_BYTES);
      end
      while (frame_bytes_queued - phase_base < PHASE_BYTES) begin
        r = $urandom_range(99);
        if (r < 65) begin
          queue_frame(make_channels(lo, hi, $urandom_range(99) < 60), BYTE_W'($urandom),
                      FRAME_BYTES);
          if ($urandom_range(3) == 0)
            queue_byte(BYTE_W'($urandom), 1'b0);
        end else if (r < 78) begin
          queue_frame(make_channels(lo, hi, 1'b1), BYTE_W'($urandom), $urandom_range(22, 1));
        end else if (r < 90) begin
          repeat ($urandom_range(3, 1)) queue_byte(BYTE_W'($urandom), 1'b0);
        end else begin
          repeat ($urandom_range(3, 1)) queue_byte(BYTE_W'($urandom), 1'($urandom));
        end
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_reports.size());
    end
    $display("Covered %0d bytes under %0d register settings: %0d frames decided, %0d committed.",
             bytes_taken, settings_used, frames_decided, frames_committed);
    $display("Checked %0d channel results, %0d mismatches.", reports_checked, errors);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
